FILE: sv/mrqs_pkg.sv
// ----------------------------------------------------------------------------
// Multicore ready queue scheduler package
// Shared constants, codes and types for the scheduler and its queue cells.
// ----------------------------------------------------------------------------
`default_nettype none
package mrqs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_CPUS    = 16;

   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CIDX_W = $clog2(MAX_CPUS);
   localparam int CCNT_W = $clog2(MAX_CPUS + 1);

   localparam int OP_W   = 2;
   localparam int CPU_W  = 4;
   localparam int ID_W   = 8;
   localparam int TIME_W = 16;
   localparam int MODE_W = 2;
   localparam int ACT_W  = 5;

   localparam logic [OP_W-1:0] OP_WAKE      = 2'd0;
   localparam logic [OP_W-1:0] OP_PREEMPT   = 2'd1;
   localparam logic [OP_W-1:0] OP_YIELD     = 2'd2;
   localparam logic [OP_W-1:0] OP_TERMINATE = 2'd3;

   localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LRTF = 2'd2;

   localparam logic ACT_DISPATCH = 1'b0;
   localparam logic ACT_PREEMPT  = 1'b1;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_SLICE  = 2'd1;
   localparam logic [1:0] REG_ACTIVE = 2'd2;

   typedef struct packed {
      logic              push;
      logic [ID_W-1:0]   push_id;
      logic [TIME_W-1:0] push_time;
      logic              take;
      logic [QIDX_W-1:0] take_idx;
      logic [QIDX_W-1:0] rd_idx;
   } queue_ctrl_type;

endpackage
`default_nettype wire

FILE: sv/mrqs_cell.sv
// ----------------------------------------------------------------------------
// Ready queue cell
// One queue entry; loads a pushed entry or its upper neighbor on removal.
// ----------------------------------------------------------------------------
`default_nettype none
module mrqs_cell (
   input  wire logic                      clock,
   input  wire logic                      push_en,
   input  wire logic                      shift_en,
   input  wire logic [mrqs_pkg::ID_W-1:0]   push_id,
   input  wire logic [mrqs_pkg::TIME_W-1:0] push_time,
   input  wire logic [mrqs_pkg::ID_W-1:0]   next_id,
   input  wire logic [mrqs_pkg::TIME_W-1:0] next_time,
   output logic      [mrqs_pkg::ID_W-1:0]   cell_id,
   output logic      [mrqs_pkg::TIME_W-1:0] cell_time
);
   import mrqs_pkg::*;

   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] time_ff, time_in;

   always_comb begin
      id_in   = id_ff;
      time_in = time_ff;
      if (push_en) begin
         id_in   = push_id;
         time_in = push_time;
      end else if (shift_en) begin
         id_in   = next_id;
         time_in = next_time;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      time_ff <= time_in;
   end

   assign cell_id   = id_ff;
   assign cell_time = time_ff;

endmodule
`default_nettype wire

FILE: sv/mrqs_queue.sv
// ----------------------------------------------------------------------------
// Ready queue
// Row of queue cells; push at the fill count, removal closes the gap.
// ----------------------------------------------------------------------------
`default_nettype none
module mrqs_queue (
   input  wire logic                          clock,
   input  wire mrqs_pkg::queue_ctrl_type      ctrl,
   input  wire logic [mrqs_pkg::QCNT_W-1:0]   count,
   output logic      [mrqs_pkg::ID_W-1:0]     rd_id,
   output logic      [mrqs_pkg::TIME_W-1:0]   rd_time
);
   import mrqs_pkg::*;

   logic [ID_W-1:0]   ids   [QUEUE_DEPTH];
   logic [TIME_W-1:0] times [QUEUE_DEPTH];
   logic [ID_W-1:0]   nids  [QUEUE_DEPTH];
   logic [TIME_W-1:0] ntimes[QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign nids[i]   = '0;
         assign ntimes[i] = '0;
      end else begin : g_mid
         assign nids[i]   = ids[i+1];
         assign ntimes[i] = times[i+1];
      end
      mrqs_cell u_cell (
         .clock     (clock),
         .push_en   (ctrl.push && (count == QCNT_W'(i))),
         .shift_en  (ctrl.take && (QIDX_W'(i) >= ctrl.take_idx)),
         .push_id   (ctrl.push_id),
         .push_time (ctrl.push_time),
         .next_id   (nids[i]),
         .next_time (ntimes[i]),
         .cell_id   (ids[i]),
         .cell_time (times[i])
      );
   end

   assign rd_id   = ids[ctrl.rd_idx];
   assign rd_time = times[ctrl.rd_idx];

endmodule
`default_nettype wire

FILE: sv/multicore_ready_queue_scheduler_top.sv
// Sequence: a FIFO or round robin process dispatch runs through the evaluate, dispatch, take
// and result states; an idle dispatch skips the take state, an LRTF dispatch adds a queue
// search and an LRTF force preempt a search of the active CPUs. The result state waits while
// the output register holds an untaken result. Throughput: one transaction at a time;
// req_tready returns as the result is loaded into the output register. Reset clears the
// queue count, marks every CPU waiting and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Multicore ready queue scheduler
// Sequencer around the queue cells, per-CPU running state and register port.
// ----------------------------------------------------------------------------
`default_nettype none
module multicore_ready_queue_scheduler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // cpu_index, proc_id, remaining_time
   input  wire logic [1:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // target_cpu, has_process, chosen_proc,
                                         // granted_slice, queue_overflow
   output logic [0:0]       rsp_tuser,   // action_kind
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mrqs_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EVAL  = 7'b0000010,
      ST_DISP  = 7'b0000100,
      ST_SCANQ = 7'b0001000,
      ST_TAKE  = 7'b0010000,
      ST_SCANC = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [TIME_W-1:0] slice_ff, slice_in;
   logic [ACT_W-1:0]  active_ff, active_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [CPU_W-1:0]  cpu_ff, cpu_in;
   logic [ID_W-1:0]   pid_ff, pid_in;
   logic [TIME_W-1:0] time_ff, time_in;

   logic [QCNT_W-1:0] count_ff, count_in;
   logic [MAX_CPUS-1:0] waiting_ff, waiting_in;
   logic [ID_W-1:0]   run_id_ff   [MAX_CPUS];
   logic [TIME_W-1:0] run_time_ff [MAX_CPUS];
   logic              run_we;

   logic [QCNT_W-1:0] qidx_ff, qidx_in;
   logic [CCNT_W-1:0] cidx_ff, cidx_in;
   logic [QIDX_W-1:0] best_ff, best_in;
   logic [TIME_W-1:0] maxv_ff, maxv_in;
   logic [CIDX_W-1:0] low_ff, low_in;
   logic [TIME_W-1:0] minv_ff, minv_in;
   logic [CIDX_W-1:0] dcpu_ff, dcpu_in;
   logic              ovf_ff, ovf_in;

   logic              res_kind_ff, res_kind_in;
   logic [CPU_W-1:0]  res_cpu_ff, res_cpu_in;
   logic              res_has_ff, res_has_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [TIME_W-1:0] res_slice_ff, res_slice_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_kind_ff, rsp_kind_in;

   queue_ctrl_type    qctrl;
   logic [ID_W-1:0]   q_rd_id;
   logic [TIME_W-1:0] q_rd_time;

   logic [CCNT_W-1:0] n_use;
   logic              cpu_ok;
   logic              do_push;
   logic              q_full;
   logic [MAX_CPUS-1:0] act_mask;
   logic              any_wait;
   logic [CIDX_W-1:0] first_wait;
   logic              req_acc;
   logic              csr_we;
   logic              out_free;

   mrqs_queue u_queue (
      .clock   (clock),
      .ctrl    (qctrl),
      .count   (count_ff),
      .rd_id   (q_rd_id),
      .rd_time (q_rd_time)
   );

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (active_ff == '0) begin
         n_use = CCNT_W'(1);
      end else if (32'(active_ff) > 32'(MAX_CPUS)) begin
         n_use = CCNT_W'(MAX_CPUS);
      end else begin
         n_use = CCNT_W'(active_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CPUS; i++) begin
         act_mask[i] = (CCNT_W'(i) < n_use);
      end
      any_wait   = |(waiting_ff & act_mask);
      first_wait = '0;
      for (int i = MAX_CPUS - 1; i >= 0; i--) begin
         if (waiting_ff[i] && act_mask[i]) begin
            first_wait = CIDX_W'(i);
         end
      end
   end

   assign cpu_ok  = (CCNT_W'(cpu_ff) < n_use);
   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = (op_ff == OP_WAKE) ||
                    ((op_ff == OP_PREEMPT) && cpu_ok && !waiting_ff[cpu_ff]);

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MODE:   csr_prdata = 32'(mode_ff);
         REG_SLICE:  csr_prdata = 32'(slice_ff);
         REG_ACTIVE: csr_prdata = 32'(active_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      slice_in  = slice_ff;
      active_in = active_ff;
      if (csr_we) begin
         unique case (csr_paddr[3:2])
            REG_MODE:   mode_in   = csr_pwdata[MODE_W-1:0];
            REG_SLICE:  slice_in  = csr_pwdata[TIME_W-1:0];
            REG_ACTIVE: active_in = csr_pwdata[ACT_W-1:0];
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cpu_in       = cpu_ff;
      pid_in       = pid_ff;
      time_in      = time_ff;
      count_in     = count_ff;
      waiting_in   = waiting_ff;
      run_we       = 1'b0;
      qidx_in      = qidx_ff;
      cidx_in      = cidx_ff;
      best_in      = best_ff;
      maxv_in      = maxv_ff;
      low_in       = low_ff;
      minv_in      = minv_ff;
      dcpu_in      = dcpu_ff;
      ovf_in       = ovf_ff;
      res_kind_in  = res_kind_ff;
      res_cpu_in   = res_cpu_ff;
      res_has_in   = res_has_ff;
      res_id_in    = res_id_ff;
      res_slice_in = res_slice_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      qctrl.push      = 1'b0;
      qctrl.push_id   = (op_ff == OP_WAKE) ? pid_ff : run_id_ff[cpu_ff];
      qctrl.push_time = time_ff;
      qctrl.take      = 1'b0;
      qctrl.take_idx  = best_ff;
      qctrl.rd_idx    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in    = req_tuser;
               cpu_in   = req_tdata[3:0];
               pid_in   = req_tdata[11:4];
               time_in  = req_tdata[27:12];
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ovf_in = do_push && q_full;
            if (do_push && !q_full) begin
               qctrl.push = 1'b1;
               count_in   = count_ff + QCNT_W'(1);
            end
            if (op_ff == OP_WAKE) begin
               if (any_wait) begin
                  dcpu_in  = first_wait;
                  state_in = ST_DISP;
               end else if (mode_ff == MODE_LRTF) begin
                  minv_in  = run_time_ff[0];
                  low_in   = '0;
                  cidx_in  = CCNT_W'(1);
                  state_in = ST_SCANC;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (cpu_ok) begin
               dcpu_in  = cpu_ff;
               state_in = ST_DISP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DISP: begin
            best_in = '0;
            maxv_in = q_rd_time;
            qidx_in = QCNT_W'(1);
            if (count_ff == '0) begin
               waiting_in[dcpu_ff] = 1'b1;
               res_kind_in  = ACT_DISPATCH;
               res_cpu_in   = dcpu_ff;
               res_has_in   = 1'b0;
               res_id_in    = '0;
               res_slice_in = '0;
               state_in     = ST_RESP;
            end else if (mode_ff == MODE_LRTF) begin
               state_in = ST_SCANQ;
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_SCANQ: begin
            qctrl.rd_idx = qidx_ff[QIDX_W-1:0];
            if (qidx_ff < count_ff) begin
               if (q_rd_time > maxv_ff) begin
                  maxv_in = q_rd_time;
                  best_in = qidx_ff[QIDX_W-1:0];
               end
               qidx_in = qidx_ff + QCNT_W'(1);
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            qctrl.rd_idx = best_ff;
            qctrl.take   = 1'b1;
            count_in     = count_ff - QCNT_W'(1);
            run_we       = 1'b1;
            waiting_in[dcpu_ff] = 1'b0;
            res_kind_in  = ACT_DISPATCH;
            res_cpu_in   = dcpu_ff;
            res_has_in   = 1'b1;
            res_id_in    = q_rd_id;
            res_slice_in = (mode_ff == MODE_RR) ? slice_ff : '0;
            state_in     = ST_RESP;
         end
         ST_SCANC: begin
            if (cidx_ff < n_use) begin
               if (run_time_ff[cidx_ff[CIDX_W-1:0]] < minv_ff) begin
                  minv_in = run_time_ff[cidx_ff[CIDX_W-1:0]];
                  low_in  = cidx_ff[CIDX_W-1:0];
               end
               cidx_in = cidx_ff + CCNT_W'(1);
            end else if (minv_ff < time_ff) begin
               res_kind_in  = ACT_PREEMPT;
               res_cpu_in   = low_ff;
               res_has_in   = 1'b0;
               res_id_in    = '0;
               res_slice_in = '0;
               state_in     = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_data_in  = {2'b00, ovf_ff, res_slice_ff, res_id_ff,
                               res_has_ff, res_cpu_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FIFO;
         slice_ff     <= '0;
         active_ff    <= ACT_W'(1);
         count_ff     <= '0;
         waiting_ff   <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         slice_ff     <= slice_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cpu_ff       <= cpu_in;
      pid_ff       <= pid_in;
      time_ff      <= time_in;
      qidx_ff      <= qidx_in;
      cidx_ff      <= cidx_in;
      best_ff      <= best_in;
      maxv_ff      <= maxv_in;
      low_ff       <= low_in;
      minv_ff      <= minv_in;
      dcpu_ff      <= dcpu_in;
      ovf_ff       <= ovf_in;
      res_kind_ff  <= res_kind_in;
      res_cpu_ff   <= res_cpu_in;
      res_has_ff   <= res_has_in;
      res_id_ff    <= res_id_in;
      res_slice_ff <= res_slice_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      if (run_we) begin
         run_id_ff[dcpu_ff]   <= q_rd_id;
         run_time_ff[dcpu_ff] <= q_rd_time;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_kind_ff;

endmodule
`default_nettype wire

FILE: sv/mrqs_checker.sv
// ----------------------------------------------------------------------------
// Multicore ready queue scheduler checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module mrqs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_preempt_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[28:4] == '0)
      else $error("force preempt carries a process");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && !rsp_tdata[4] |-> rsp_tdata[28:5] == '0)
      else $error("idle dispatch carries a process");

endmodule

bind multicore_ready_queue_scheduler_top mrqs_checker u_mrqs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

FILE: sim/tb_multicore_ready_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// Ready queue scheduler testbench
// Drives scheduling events and register writes into the scheduler, predicts
// every dispatch and force preempt request with a cycle-free model of the
// queue and per-CPU state, and checks each result transaction in order under
// random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_multicore_ready_queue_scheduler_top;
   import mrqs_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 400;

   typedef struct {
      logic        kind;
      logic [3:0]  cpu;
      logic        has;
      logic [7:0]  proc;
      logic [15:0] slice;
      logic        ovf;
   } sched_result_type;

   class sched_scoreboard;
      logic [1:0]  mode = MODE_FIFO;
      logic [15:0] slice_len = '0;
      logic [4:0]  active = 5'd1;
      logic [7:0]  q_id[QUEUE_DEPTH];
      logic [15:0] q_t[QUEUE_DEPTH];
      int          q_n = 0;
      logic [7:0]  run_id[MAX_CPUS];
      logic [15:0] run_t[MAX_CPUS];
      logic [15:0] waiting = '1;
      sched_result_type expected_q[$];
      int errors = 0;
      int n_items = 0;
      int n_results = 0;
      int n_ovf = 0;
      int n_force = 0;

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         if (idx == REG_MODE) mode = val[1:0];
         else if (idx == REG_SLICE) slice_len = val[15:0];
         else if (idx == REG_ACTIVE) active = val[4:0];
      endfunction

      function int cpus_used();
         if (active == 0) return 1;
         if (active > MAX_CPUS) return MAX_CPUS;
         return active;
      endfunction

      function logic push(logic [7:0] id, logic [15:0] t);
         if (q_n >= QUEUE_DEPTH) return 1'b1;
         q_id[q_n] = id;
         q_t[q_n] = t;
         q_n++;
         return 1'b0;
      endfunction

      function void add(logic kind, int cpu, logic has, logic [7:0] id,
                        logic [15:0] sl, logic ovf);
         sched_result_type r;
         r.kind = kind;
         r.cpu = cpu[3:0];
         r.has = has;
         r.proc = id;
         r.slice = sl;
         r.ovf = ovf;
         expected_q.push_back(r);
      endfunction

      function void dispatch(int cpu, logic ovf);
         int k;
         if (q_n == 0) begin
            waiting[cpu] = 1'b1;
            add(ACT_DISPATCH, cpu, 1'b0, 8'd0, 16'd0, ovf);
            return;
         end
         k = 0;
         if (mode == MODE_LRTF)
            for (int i = 1; i < q_n; i++) if (q_t[i] > q_t[k]) k = i;
         run_id[cpu] = q_id[k];
         run_t[cpu] = q_t[k];
         waiting[cpu] = 1'b0;
         add(ACT_DISPATCH, cpu, 1'b1, q_id[k], (mode == MODE_RR) ? slice_len : 16'd0, ovf);
         for (int i = k; i + 1 < q_n; i++) begin
            q_id[i] = q_id[i+1];
            q_t[i] = q_t[i+1];
         end
         q_n--;
      endfunction

      function void note(logic [1:0] op, logic [3:0] cpu, logic [7:0] pid, logic [15:0] t);
         int n;
         int low;
         logic ovf;
         n = cpus_used();
         ovf = 1'b0;
         n_items++;
         if (op == OP_WAKE) begin
            ovf = push(pid, t);
            for (int i = 0; i < n; i++)
               if (waiting[i]) begin
                  dispatch(i, ovf);
                  return;
               end
            if (mode == MODE_LRTF) begin
               low = 0;
               for (int i = 1; i < n; i++) if (run_t[i] < run_t[low]) low = i;
               if (run_t[low] < t) add(ACT_PREEMPT, low, 1'b0, 8'd0, 16'd0, ovf);
            end
            return;
         end
         if (cpu >= n) return;
         if (op == OP_PREEMPT && !waiting[cpu]) ovf = push(run_id[cpu], t);
         dispatch(cpu, ovf);
      endfunction

      function void check(sched_result_type act);
         sched_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result kind=%0d cpu=%0d proc=%0d", $time,
                     act.kind, act.cpu, act.proc);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         n_results++;
         if (act.ovf) n_ovf++;
         if (act.kind == ACT_PREEMPT) n_force++;
         if (act.kind !== e.kind) begin
            $display("%0t: action_kind expected %0d actual %0d", $time, e.kind, act.kind);
            errors++;
         end
         if (act.cpu !== e.cpu) begin
            $display("%0t: target_cpu expected %0d actual %0d", $time, e.cpu, act.cpu);
            errors++;
         end
         if (act.has !== e.has) begin
            $display("%0t: has_process expected %0d actual %0d", $time, e.has, act.has);
            errors++;
         end
         if (act.proc !== e.proc) begin
            $display("%0t: chosen_proc expected %0d actual %0d", $time, e.proc, act.proc);
            errors++;
         end
         if (act.slice !== e.slice) begin
            $display("%0t: granted_slice expected %0d actual %0d", $time, e.slice, act.slice);
            errors++;
         end
         if (act.ovf !== e.ovf) begin
            $display("%0t: queue_overflow expected %0d actual %0d", $time, e.ovf, act.ovf);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire logic   req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   wire logic   rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire logic [31:0] rsp_tdata;
   wire logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire logic [31:0] csr_prdata;
   wire logic   csr_pready;

   logic        req_fire = 1'b0;
   logic        rsp_fire = 1'b0;
   logic        csr_fire = 1'b0;
   logic [32:0] rsp_snap = '0;
   logic        quiet = 1'b0;
   logic        hold_on = 1'b0;
   int          hold_cnt = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;

   sched_scoreboard sb = new();

   multicore_ready_queue_scheduler_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Handshakes are sampled on the falling edge ahead of the rising edge that completes them.
   always @(negedge clock) begin
      req_fire <= req_tvalid & req_tready;
      rsp_fire <= rsp_tvalid & rsp_tready;
      csr_fire <= csr_psel & csr_penable & csr_pwrite & csr_pready;
      rsp_snap <= {rsp_tuser, rsp_tdata};
   end

   always @(posedge clock) begin
      sched_result_type act;
      if (!reset && rsp_fire) begin
         act.kind = rsp_snap[32];
         act.cpu = rsp_snap[3:0];
         act.has = rsp_snap[4];
         act.proc = rsp_snap[12:5];
         act.slice = rsp_snap[28:13];
         act.ovf = rsp_snap[29];
         sb.check(act);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_on && hold_cnt < LONG_HOLD) begin
         rsp_tready <= 1'b0;
         hold_cnt++;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         rsp_tready <= ($urandom_range(0, 2) != 0);
      end else begin
         burst_left--;
      end
   end

   always @(posedge clock) begin
      if (req_fire || rsp_fire || csr_fire || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] op, logic [3:0] cpu, logic [7:0] pid, logic [15:0] t);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'd0, t, pid, cpu};
      do @(posedge clock); while (!req_fire);
      sb.note(op, cpu, pid, t);
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_fire);
      sb.write_reg(idx, val);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [1:0] mode, logic [15:0] sl, logic [4:0] act);
      wait_drained();
      csr_write(REG_MODE, 32'(mode));
      csr_write(REG_SLICE, 32'(sl));
      csr_write(REG_ACTIVE, 32'(act));
   endtask

   task automatic random_item();
      logic [1:0]  op;
      logic [3:0]  cpu;
      logic [15:0] t;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_WAKE;
      else if (r < 65) op = OP_PREEMPT;
      else if (r < 80) op = OP_YIELD;
      else op = OP_TERMINATE;
      if ($urandom_range(0, 9) == 0) cpu = 4'($urandom_range(0, 15));
      else cpu = 4'($urandom_range(0, sb.cpus_used() - 1));
      r = $urandom_range(0, 9);
      if (r == 0) t = 16'd0;
      else if (r == 1) t = 16'hFFFF;
      else t = 16'($urandom());
      send_item(op, cpu, 8'($urandom_range(0, 255)), t);
   endtask

   initial begin
      logic [4:0] act;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(MODE_FIFO, 16'd0, 5'd2);
      send_item(OP_WAKE, 4'd0, 8'd5, 16'd100);
      send_item(OP_WAKE, 4'd0, 8'd6, 16'hFFFF);
      send_item(OP_WAKE, 4'd0, 8'd7, 16'd0);
      send_item(OP_PREEMPT, 4'd0, 8'd0, 16'hFFFF);
      send_item(OP_YIELD, 4'd1, 8'd0, 16'd0);
      send_item(OP_TERMINATE, 4'd0, 8'd0, 16'd0);
      send_item(OP_TERMINATE, 4'd1, 8'd0, 16'd0);
      send_item(OP_TERMINATE, 4'd15, 8'd0, 16'd0);
      send_item(OP_PREEMPT, 4'd1, 8'd0, 16'd9);
      configure(MODE_LRTF, 16'hFFFF, 5'd2);
      send_item(OP_WAKE, 4'd0, 8'd255, 16'd10);
      send_item(OP_WAKE, 4'd0, 8'd30, 16'd20);
      send_item(OP_WAKE, 4'd0, 8'd31, 16'd40);
      send_item(OP_WAKE, 4'd0, 8'd32, 16'd40);
      send_item(OP_PREEMPT, 4'd0, 8'd0, 16'd5);
      configure(2'd3, 16'd7, 5'd0);
      for (int i = 0; i < 17; i++) send_item(OP_WAKE, 4'd0, i[7:0], 16'd1);
      send_item(OP_PREEMPT, 4'd0, 8'd0, 16'd3);
      configure(MODE_RR, 16'd1234, 5'd31);
      send_item(OP_YIELD, 4'd15, 8'd0, 16'd0);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: configure(MODE_RR, 16'hFFFF, 5'd16);
            1: configure(MODE_LRTF, 16'd0, 5'd1);
            2: configure(MODE_FIFO, 16'($urandom()), 5'd4);
            default: begin
               act = 5'($urandom_range(0, 31));
               configure(2'($urandom_range(0, 3)), 16'($urandom()), act);
            end
         endcase
         if (ph == 7) quiet = 1'b1;
         for (int i = 0; i < 165; i++) begin
            if (ph == 2 && i == 20) hold_on = 1'b1;
            if (ph == 4 && i == 80) wait_drained();
            sender_gap();
            random_item();
         end
      end

      wait_drained();
      $display("Covered %0d events over several policies, %0d results checked,",
               sb.n_items, sb.n_results);
      $display("including %0d queue overflows and %0d force preempt requests.",
               sb.n_ovf, sb.n_force);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
sv/mrqs_pkg.sv
sv/mrqs_cell.sv
sv/mrqs_queue.sv
sv/multicore_ready_queue_scheduler_top.sv
sv/mrqs_checker.sv
sim/tb_multicore_ready_queue_scheduler_top.sv
